// File: hw/rtl/pmsc_pkg.sv
package pmsc_pkg;

	localparam int MAX_MOTIF_LEN_DEF = 32;
	localparam int WEIGHT_BITS_DEF   = 16;
	localparam int POSITION_BITS_DEF = 32;

	localparam int NUM_BASES     = 5;
	localparam int BASE_W        = 3;
	localparam int LOAD_W        = 16;
	localparam int THRESH_W      = 21;
	localparam int LEN_CFG_W     = 6;
	localparam int CFG_DATA_W    = 21;
	localparam int CFG_IDX_W     = 2;
	localparam int START_W       = 32;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BASE  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MOTIF_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;

	localparam logic [BASE_W-1:0] BASE_N = 3'd0;
	localparam logic [BASE_W-1:0] BASE_T = 3'd4;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_BASE,
		CMD_CLEAR
	} cmd_kind_t;

	function automatic logic [BASE_W-1:0] complement(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		if (b == BASE_N) r = BASE_N;
		else r = BASE_W'(NUM_BASES) - b;
		return r;
	endfunction

endpackage

// File: hw/rtl/pmsc_in_if.sv
interface pmsc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [4:0]  load_position;
	logic [2:0]  load_base;
	logic signed [15:0] load_weight;
	logic [2:0]  base_code;

	modport source (output valid, opcode, load_position, load_base, load_weight, base_code,
		input ready);
	modport sink (input valid, opcode, load_position, load_base, load_weight, base_code,
		output ready);
endinterface

// File: hw/rtl/pmsc_out_if.sv
interface pmsc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] window_start;
	logic        forward_hit;
	logic        reverse_hit;

	modport source (output valid, window_start, forward_hit, reverse_hit, input ready);
	modport sink (input valid, window_start, forward_hit, reverse_hit, output ready);
endinterface

// File: hw/rtl/pmsc_ram.sv
module pmsc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 160,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

// File: hw/rtl/pmsc_front.sv
module pmsc_front import pmsc_pkg::*; #(
	parameter int MAX_MOTIF_LEN = MAX_MOTIF_LEN_DEF,
	parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
	parameter int AW            = $clog2(MAX_MOTIF_LEN * NUM_BASES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	pmsc_in_if.sink                items,
	output logic                   cmd_valid,
	input  logic                   cmd_pop,
	output cmd_kind_t              cmd_kind,
	output logic [AW-1:0]          cmd_addr,
	output logic [WEIGHT_BITS-1:0] cmd_weight,
	output logic [BASE_W-1:0]      cmd_base
);
	localparam longint WHI = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
	localparam longint WLO = -WHI - 1;

	cmd_kind_t              kind;
	logic                   keep;
	logic [AW-1:0]          addr;
	logic [WEIGHT_BITS-1:0] weight;
	logic [BASE_W-1:0]      base;
	longint                 w_l;
	longint                 sat_l;

	always_comb begin
		w_l   = longint'(items.load_weight);
		sat_l = (w_l > WHI) ? WHI : ((w_l < WLO) ? WLO : w_l);
		weight = WEIGHT_BITS'(sat_l);
		addr = AW'(AW'(items.load_position) * AW'(NUM_BASES) + AW'(items.load_base));
		base = (items.base_code > BASE_T) ? BASE_N : items.base_code;
		kind = CMD_LOAD;
		keep = 1'b0;
		unique case (items.opcode)
			OP_LOAD: begin
				kind = CMD_LOAD;
				keep = (items.load_base <= BASE_T) &&
					(int'(items.load_position) < MAX_MOTIF_LEN);
			end
			OP_BASE: begin
				kind = CMD_BASE;
				keep = 1'b1;
			end
			OP_CLEAR: begin
				kind = CMD_CLEAR;
				keep = 1'b1;
			end
			default: begin
				kind = CMD_LOAD;
				keep = 1'b0;
			end
		endcase
	end

	cmd_kind_t              kind_q   [2];
	logic [AW-1:0]          addr_q   [2];
	logic [WEIGHT_BITS-1:0] weight_q [2];
	logic [BASE_W-1:0]      base_q   [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             cnt_q;
	logic                   push;
	logic                   pop;

	assign items.ready = (cnt_q != 2'd2);
	assign push = items.valid && items.ready && keep;
	assign pop  = cmd_pop && (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q]   <= kind;
			addr_q[wr_ptr_q]   <= addr;
			weight_q[wr_ptr_q] <= weight;
			base_q[wr_ptr_q]   <= base;
		end
	end

	assign cmd_valid  = (cnt_q != 2'd0);
	assign cmd_kind   = kind_q[rd_ptr_q];
	assign cmd_addr   = addr_q[rd_ptr_q];
	assign cmd_weight = weight_q[rd_ptr_q];
	assign cmd_base   = base_q[rd_ptr_q];
endmodule

// File: hw/rtl/pmsc_back.sv
module pmsc_back import pmsc_pkg::*; #(
	parameter int MAX_MOTIF_LEN = MAX_MOTIF_LEN_DEF,
	parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	parameter int AW            = $clog2(MAX_MOTIF_LEN * NUM_BASES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   cmd_valid,
	output logic                   cmd_pop,
	input  cmd_kind_t              cmd_kind,
	input  logic [AW-1:0]          cmd_addr,
	input  logic [WEIGHT_BITS-1:0] cmd_weight,
	input  logic [BASE_W-1:0]      cmd_base,
	pmsc_out_if.source             results
);
	localparam int LW = $clog2(MAX_MOTIF_LEN + 1);
	localparam int JW = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
	localparam int SW = WEIGHT_BITS + LW + 1;
	localparam int CW = (SW > THRESH_W) ? SW : THRESH_W;
	localparam int PW = POSITION_BITS;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

	state_t                state_q;
	logic [LEN_CFG_W-1:0]  len_cfg_q;
	logic signed [THRESH_W-1:0] thr_q;
	logic [BASE_W-1:0]     win_q  [MAX_MOTIF_LEN];
	logic [BASE_W-1:0]     win_nx [MAX_MOTIF_LEN];
	logic [BASE_W-1:0]     scan_q [MAX_MOTIF_LEN];
	logic [LW-1:0]         fill_q;
	logic [LW-1:0]         fill_nx;
	logic [PW-1:0]         seen_q;
	logic [PW-1:0]         seen_nx;
	logic [LW-1:0]         len_eff;
	logic [LW-1:0]         len_q;
	logic [JW-1:0]         j_q;
	logic                  pend_s1;
	logic signed [SW-1:0]  fwd_q;
	logic signed [SW-1:0]  rev_q;
	logic [PW-1:0]         start_q;
	logic [AW-1:0]         raddr_f;
	logic [AW-1:0]         raddr_r;
	logic [WEIGHT_BITS-1:0] rdata_f;
	logic [WEIGHT_BITS-1:0] rdata_r;
	logic [LW-1:0]         pos_f;
	logic signed [CW-1:0]  fwd_c;
	logic signed [CW-1:0]  rev_c;
	logic signed [CW-1:0]  thr_c;
	logic                  fh;
	logic                  rh;
	logic                  emit;
	logic                  ram_we;

	always_comb begin
		if (len_cfg_q == '0) len_eff = LW'(1);
		else if (int'(len_cfg_q) > MAX_MOTIF_LEN) len_eff = LW'(MAX_MOTIF_LEN);
		else len_eff = LW'(len_cfg_q);
		fill_nx = (fill_q == LW'(MAX_MOTIF_LEN)) ? fill_q : fill_q + LW'(1);
		seen_nx = seen_q + PW'(1);
		win_nx[0] = cmd_base;
		for (int i = 1; i < MAX_MOTIF_LEN; i++) win_nx[i] = win_q[i-1];
		pos_f   = len_q - LW'(1) - LW'(j_q);
		raddr_f = AW'(AW'(pos_f) * AW'(NUM_BASES) + AW'(scan_q[0]));
		raddr_r = AW'(AW'(j_q) * AW'(NUM_BASES) + AW'(complement(scan_q[0])));
		fwd_c = CW'(fwd_q);
		rev_c = CW'(rev_q);
		thr_c = CW'(thr_q);
		fh = fwd_c > thr_c;
		rh = rev_c > thr_c;
		emit = (state_q == S_DONE) && (fh || rh) && (!results.valid || results.ready);
	end

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;
	assign ram_we  = cmd_pop && (cmd_kind == CMD_LOAD);

	pmsc_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_MOTIF_LEN * NUM_BASES), .AW(AW)) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (cmd_addr),
		.wdata   (cmd_weight),
		.raddr_a (raddr_f),
		.rdata_a (rdata_f),
		.raddr_b (raddr_r),
		.rdata_b (rdata_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			len_cfg_q <= LEN_CFG_W'(1);
			thr_q     <= -THRESH_W'(1024);
			fill_q    <= '0;
			seen_q    <= '0;
			pend_s1   <= 1'b0;
			results.valid <= 1'b0;
			for (int i = 0; i < MAX_MOTIF_LEN; i++) win_q[i] <= BASE_N;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MOTIF_LEN) len_cfg_q <= cfg_data[LEN_CFG_W-1:0];
				else if (cfg_index == CFG_THRESHOLD) thr_q <= $signed(cfg_data[THRESH_W-1:0]);
			end
			results.valid <= emit || (results.valid && !results.ready);
			pend_s1 <= (state_q == S_SCAN);
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd_kind)
							CMD_CLEAR: begin
								fill_q <= '0;
								seen_q <= '0;
								for (int i = 0; i < MAX_MOTIF_LEN; i++) win_q[i] <= BASE_N;
							end
							CMD_BASE: begin
								win_q  <= win_nx;
								fill_q <= fill_nx;
								seen_q <= seen_nx;
								if (fill_nx >= len_eff) state_q <= S_SCAN;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (j_q == JW'(len_q - LW'(1))) state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_DONE;
				S_DONE: begin
					if (!(fh || rh) || emit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			scan_q  <= win_nx;
			len_q   <= len_eff;
			j_q     <= '0;
			fwd_q   <= '0;
			rev_q   <= '0;
			start_q <= seen_nx - PW'(len_eff);
		end else begin
			if (state_q == S_SCAN) begin
				for (int i = 0; i < MAX_MOTIF_LEN - 1; i++) scan_q[i] <= scan_q[i+1];
				scan_q[MAX_MOTIF_LEN-1] <= BASE_N;
				j_q <= j_q + JW'(1);
			end
			if (pend_s1) begin
				fwd_q <= fwd_q + SW'($signed(rdata_f));
				rev_q <= rev_q + SW'($signed(rdata_r));
			end
		end
		if (emit) begin
			results.window_start <= START_W'(start_q);
			results.forward_hit  <= fh;
			results.reverse_hit  <= rh;
		end
	end
endmodule

// File: hw/rtl/pwm_motif_scanner.sv
// channel  dir  modport              payload
// items    in   pmsc_in_if.sink      opcode, load_position, load_base, load_weight, base_code
// results  out  pmsc_out_if.source   window_start, forward_hit, reverse_hit
// cfg      in   write port           cfg_we, cfg_index, cfg_data
//
// Load and new-sequence transactions are handled by the back end without leaving idle.
// A nucleotide that completes a window moves the back end through scan, drain and done:
// it walks the window one position per cycle over the two read ports of the
// weight RAM. A two-entry queue lets the front accept while the back works.
// Reset clears window, counters, valid; sets length 1, threshold -1024; not the weight RAM.
// The back end waits in its final state while a pending result is not taken.
module pwm_motif_scanner import pmsc_pkg::*; #(
	parameter int MAX_MOTIF_LEN = MAX_MOTIF_LEN_DEF,
	parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pmsc_in_if.sink               items,
	pmsc_out_if.source            results
);
	localparam int AW = $clog2(MAX_MOTIF_LEN * NUM_BASES);

	logic                   cmd_valid;
	logic                   cmd_pop;
	cmd_kind_t              cmd_kind;
	logic [AW-1:0]          cmd_addr;
	logic [WEIGHT_BITS-1:0] cmd_weight;
	logic [BASE_W-1:0]      cmd_base;

	pmsc_front #(.MAX_MOTIF_LEN(MAX_MOTIF_LEN), .WEIGHT_BITS(WEIGHT_BITS), .AW(AW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd_kind   (cmd_kind),
		.cmd_addr   (cmd_addr),
		.cmd_weight (cmd_weight),
		.cmd_base   (cmd_base)
	);

	pmsc_back #(
		.MAX_MOTIF_LEN (MAX_MOTIF_LEN),
		.WEIGHT_BITS   (WEIGHT_BITS),
		.POSITION_BITS (POSITION_BITS),
		.AW            (AW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd_kind   (cmd_kind),
		.cmd_addr   (cmd_addr),
		.cmd_weight (cmd_weight),
		.cmd_base   (cmd_base),
		.results    (results)
	);
endmodule
